// ===== hw/rtl/smeu_pkg.sv =====
`timescale 1ns / 1ps

package smeu_pkg;

    // Stack and program counter sizing
    localparam int STACK_WORDS = 1024;
    localparam int PC_BITS     = 16;
    localparam int SP_BITS     = $clog2(STACK_WORDS + 1);
    localparam int ADDR_BITS   = $clog2(STACK_WORDS);

    // Field widths fixed by the port list
    localparam int OP_BITS    = 4;
    localparam int WORD_BITS  = 64;
    localparam int NPC_BITS   = 16;
    localparam int DEPTH_BITS = 11;
    localparam int FAULT_BITS = 2;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [OP_BITS-1:0] {
        OP_HALT  = 4'd0,
        OP_PUSH  = 4'd1,
        OP_LABEL = 4'd2,
        OP_JUMP  = 4'd3,
        OP_JZ    = 4'd4,
        OP_RET   = 4'd5,
        OP_DUP   = 4'd6,
        OP_SWAP  = 4'd7,
        OP_DROP  = 4'd8,
        OP_EQ    = 4'd9,
        OP_GE    = 4'd10,
        OP_ADD   = 4'd11
    } t_op;

    typedef enum logic [FAULT_BITS-1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_UNDER = 2'd1,
        FAULT_OVER  = 2'd2
    } t_fault;

endpackage

// ===== hw/rtl/smeu_alu.sv =====
`timescale 1ns / 1ps

module smeu_alu (
    input  smeu_pkg::t_op   i_op,
    input  smeu_pkg::t_word i_below,
    input  smeu_pkg::t_word i_top,
    output smeu_pkg::t_word o_result
);
    import smeu_pkg::*;

    // Combine the second word (below) with the top word
    always_comb begin
        case (i_op)
            OP_EQ:   o_result = (i_below == i_top) ? t_word'(1) : '0;
            OP_GE:   o_result = ($signed(i_below) >= $signed(i_top)) ? t_word'(1) : '0;
            default: o_result = i_below + i_top;
        endcase
    end

endmodule

// ===== hw/rtl/stack_machine_execute_unit.sv =====
`timescale 1ns / 1ps

// Stack machine execute unit. Each accepted word (start high while busy is low)
// carries one instruction; the unit returns one result per instruction, shown for
// a single cycle with o_valid, and the receiver cannot stall it. For each
// instruction the single-port stack memory is read in the accept cycle; in
// the following cycle (busy high) the instruction executes and writes back, and
// the result appears in the cycle after that, when the next word may already be
// accepted. The top of stack lives in a register, the rest in the memory, so no
// instruction needs more than one memory read and one write. No clearing pass
// runs after reset; the unit is ready as soon as reset releases.
module stack_machine_execute_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [smeu_pkg::OP_BITS-1:0]        i_op,
    input  logic signed [smeu_pkg::WORD_BITS-1:0] i_immediate,
    output logic                                o_valid,
    output logic [smeu_pkg::NPC_BITS-1:0]       o_next_pc,
    output logic signed [smeu_pkg::WORD_BITS-1:0] o_top_value,
    output logic [smeu_pkg::DEPTH_BITS-1:0]     o_depth,
    output logic                                o_halted,
    output logic [smeu_pkg::FAULT_BITS-1:0]     o_fault
);
    import smeu_pkg::*;

    // Architectural state
    logic [SP_BITS-1:0]   r_sp, n_sp;
    logic [PC_BITS-1:0]   r_pc, n_pc;
    logic                 r_halt, n_halt;
    t_word                r_top, n_top;

    // Instruction held for the execute cycle
    logic                 r_busy;
    t_op                  r_op;
    t_word                r_imm;
    logic [ADDR_BITS-1:0] r_addr;

    // Stack memory (entries below the top word)
    t_word                mem [STACK_WORDS];
    t_word                r_rd;
    logic [ADDR_BITS-1:0] rd_addr, wa, mem_addr;
    logic                 we;
    t_word                wd;

    logic                 accept;
    t_fault               fault;
    logic [PC_BITS-1:0]   pc_inc;
    logic                 imm_ge_sp, imm_gt_sp, imm_zero, sp_full;
    logic [SP_BITS-1:0]   drop_sp;
    t_word                alu_result;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    // Pick the read address from the incoming instruction
    always_comb begin
        case (t_op'(i_op))
            OP_DUP, OP_SWAP, OP_DROP:
                rd_addr = ADDR_BITS'(r_sp - SP_BITS'(1) - i_immediate[SP_BITS-1:0]);
            default:
                rd_addr = ADDR_BITS'(r_sp - SP_BITS'(2));
        endcase
    end

    // Read in the accept cycle, write back in the execute cycle
    assign mem_addr = r_busy ? wa : rd_addr;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[mem_addr] <= wd;
        end
        r_rd <= mem[mem_addr];
    end

    smeu_alu u_alu (
        .i_op     (r_op),
        .i_below  (r_rd),
        .i_top    (r_top),
        .o_result (alu_result)
    );

    assign pc_inc    = r_pc + PC_BITS'(1);
    assign imm_ge_sp = r_imm >= WORD_BITS'(r_sp);
    assign imm_gt_sp = r_imm > WORD_BITS'(r_sp);
    assign imm_zero  = (r_imm == '0);
    assign sp_full   = (r_sp >= SP_BITS'(STACK_WORDS));
    assign drop_sp   = r_sp - r_imm[SP_BITS-1:0];

    // Execute the held instruction
    always_comb begin
        n_sp   = r_sp;
        n_pc   = r_pc;
        n_top  = r_top;
        n_halt = r_halt;
        fault  = FAULT_NONE;
        we     = 1'b0;
        wa     = ADDR_BITS'(r_sp - SP_BITS'(1));
        wd     = r_top;
        if (r_busy && !r_halt) begin
            unique case (r_op)
                OP_HALT: begin
                    n_halt = 1'b1;
                end
                OP_PUSH: begin
                    if (sp_full) begin
                        fault = FAULT_OVER;
                    end else begin
                        we    = (r_sp != '0);
                        n_top = r_imm;
                        n_sp  = r_sp + SP_BITS'(1);
                        n_pc  = pc_inc;
                    end
                end
                OP_JUMP: begin
                    n_pc = r_imm[PC_BITS-1:0];
                end
                OP_JZ: begin
                    if (r_sp == '0) begin
                        fault = FAULT_UNDER;
                    end else begin
                        n_sp  = r_sp - SP_BITS'(1);
                        n_top = r_rd;
                        n_pc  = (r_top == '0) ? r_imm[PC_BITS-1:0] : pc_inc;
                    end
                end
                OP_RET: begin
                    if (r_sp == '0) begin
                        fault = FAULT_UNDER;
                    end else begin
                        n_sp  = r_sp - SP_BITS'(1);
                        n_top = r_rd;
                        n_pc  = r_top[PC_BITS-1:0];
                    end
                end
                OP_DUP: begin
                    if (imm_ge_sp) begin
                        fault = FAULT_UNDER;
                    end else if (sp_full) begin
                        fault = FAULT_OVER;
                    end else begin
                        we    = 1'b1;
                        n_top = imm_zero ? r_top : r_rd;
                        n_sp  = r_sp + SP_BITS'(1);
                        n_pc  = pc_inc;
                    end
                end
                OP_SWAP: begin
                    if (imm_ge_sp) begin
                        fault = FAULT_UNDER;
                    end else begin
                        we    = !imm_zero;
                        wa    = r_addr;
                        n_top = imm_zero ? r_top : r_rd;
                        n_pc  = pc_inc;
                    end
                end
                OP_DROP: begin
                    if (imm_gt_sp) begin
                        fault = FAULT_UNDER;
                    end else begin
                        n_sp  = drop_sp;
                        n_top = imm_zero ? r_top : r_rd;
                        n_pc  = pc_inc;
                    end
                end
                OP_EQ, OP_GE, OP_ADD: begin
                    if (r_sp < SP_BITS'(2)) begin
                        fault = FAULT_UNDER;
                    end else begin
                        n_sp  = r_sp - SP_BITS'(1);
                        n_top = alu_result;
                        n_pc  = pc_inc;
                    end
                end
                default: begin
                    n_pc = pc_inc;
                end
            endcase
        end
    end

    // Hold state, capture instructions and register results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp     <= '0;
            r_pc     <= '0;
            r_halt   <= 1'b0;
            r_busy   <= 1'b0;
            o_valid  <= 1'b0;
            o_halted <= 1'b0;
        end else begin
            r_busy  <= accept;
            o_valid <= r_busy;
            if (r_busy) begin
                r_sp        <= n_sp;
                r_pc        <= n_pc;
                r_halt      <= n_halt;
                o_halted    <= n_halt;
                o_next_pc   <= NPC_BITS'(n_pc);
                o_depth     <= DEPTH_BITS'(n_sp);
                o_top_value <= (n_sp == '0) ? '0 : n_top;
                o_fault     <= fault;
            end
        end
    end

    // Payload registers without reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_op'(i_op);
            r_imm  <= i_immediate;
            r_addr <= rd_addr;
        end
        if (r_busy) begin
            r_top <= n_top;
        end
    end

endmodule

// ===== hw/rtl/smeu_chk.sv =====
`timescale 1ns / 1ps

module smeu_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_valid,
    input logic                                o_halted,
    input logic [smeu_pkg::DEPTH_BITS-1:0]     o_depth,
    input logic [smeu_pkg::WORD_BITS-1:0]      o_top_value
);
    import smeu_pkg::*;

    // An accepted word occupies the unit in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // Execute lasts one cycle and is followed by its result
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy && o_valid)
        else $error("execute cycle not followed by result");

    // A result only follows an execute cycle
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without execute");

    // Halt is sticky
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_halted |=> o_halted)
        else $error("halted flag dropped");

    // Empty stack reports a zero top word
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_depth == '0) |-> (o_top_value == '0))
        else $error("empty stack with nonzero top");

endmodule

bind stack_machine_execute_unit smeu_chk u_smeu_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_halted    (o_halted),
    .o_depth     (o_depth),
    .o_top_value (o_top_value)
);

// ===== verif/tb_stack_machine_execute_unit.sv =====
`timescale 1ns / 1ps

module tb_stack_machine_execute_unit;
    import smeu_pkg::*;

    // Opcodes outside the named set behave as label
    localparam logic [OP_BITS-1:0] OP_SPARE_LO = 4'd12;
    localparam logic [OP_BITS-1:0] OP_SPARE_HI = 4'd15;

    localparam t_word WORD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam t_word WORD_MIN = 64'h8000_0000_0000_0000;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int MIXED_ITEMS   = 100;
    localparam int DIRECTED_ROWS = 25;

    typedef struct {
        logic [NPC_BITS-1:0]   next_pc;
        t_word                 top_value;
        logic [DEPTH_BITS-1:0] depth;
        logic                  halted;
        logic [FAULT_BITS-1:0] fault;
    } t_machine_status;

    typedef struct {
        logic [OP_BITS-1:0]    op;
        t_word                 imm;
        bit                    typed;
        logic [NPC_BITS-1:0]   next_pc;
        t_word                 top_value;
        logic [DEPTH_BITS-1:0] depth;
        logic                  halted;
        logic [FAULT_BITS-1:0] fault;
    } t_directed_row;

    // DUT ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic [OP_BITS-1:0]    i_op        = OP_HALT;
    t_word                 i_immediate = '0;
    logic                  o_valid;
    logic [NPC_BITS-1:0]   o_next_pc;
    t_word                 o_top_value;
    logic [DEPTH_BITS-1:0] o_depth;
    logic                  o_halted;
    logic [FAULT_BITS-1:0] o_fault;

    // Shadow machine state
    t_word              operand_words [STACK_WORDS];
    int unsigned        word_count = 0;
    logic [PC_BITS-1:0] fetch_pc   = '0;
    logic               halt_seen  = 1'b0;

    t_machine_status pending_status [$];
    t_machine_status no_status;
    t_directed_row   directed_rows [DIRECTED_ROWS];

    int error_count    = 0;
    int checked_count  = 0;
    int accepted_count = 0;
    int peak_depth     = 0;
    int burst_left     = 0;
    int cycle_count    = 0;

    stack_machine_execute_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_immediate (i_immediate),
        .o_valid     (o_valid),
        .o_next_pc   (o_next_pc),
        .o_top_value (o_top_value),
        .o_depth     (o_depth),
        .o_halted    (o_halted),
        .o_fault     (o_fault)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Count and print one mismatch line
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH: %s", msg);
    endtask

    // Execute one instruction on the shadow machine and return its status
    task automatic execute_instr(input logic [OP_BITS-1:0] op, input t_word imm,
                                 output t_machine_status status);
        logic [FAULT_BITS-1:0] fault;
        logic [PC_BITS-1:0]    pc_inc;
        int unsigned           sp;
        int unsigned           far_idx;
        t_word                 lhs;
        t_word                 rhs;
        t_word                 held;
        fault  = FAULT_NONE;
        sp     = word_count;
        pc_inc = fetch_pc + 1'b1;
        if (!halt_seen) begin
            case (op)
                OP_HALT: begin
                    halt_seen = 1'b1;
                end
                OP_PUSH: begin
                    if (sp >= STACK_WORDS) begin
                        fault = FAULT_OVER;
                    end else begin
                        operand_words[sp] = imm;
                        word_count = sp + 1;
                        fetch_pc = pc_inc;
                    end
                end
                OP_JUMP: begin
                    fetch_pc = imm[PC_BITS-1:0];
                end
                OP_JZ: begin
                    if (sp < 1) begin
                        fault = FAULT_UNDER;
                    end else begin
                        word_count = sp - 1;
                        fetch_pc = (operand_words[sp-1] == '0) ? imm[PC_BITS-1:0] : pc_inc;
                    end
                end
                OP_RET: begin
                    if (sp < 1) begin
                        fault = FAULT_UNDER;
                    end else begin
                        word_count = sp - 1;
                        fetch_pc = operand_words[sp-1][PC_BITS-1:0];
                    end
                end
                OP_DUP: begin
                    // depth is checked before room
                    if (imm >= t_word'(sp)) begin
                        fault = FAULT_UNDER;
                    end else if (sp >= STACK_WORDS) begin
                        fault = FAULT_OVER;
                    end else begin
                        operand_words[sp] = operand_words[sp - 1 - int'(imm[31:0])];
                        word_count = sp + 1;
                        fetch_pc = pc_inc;
                    end
                end
                OP_SWAP: begin
                    if (imm >= t_word'(sp)) begin
                        fault = FAULT_UNDER;
                    end else begin
                        far_idx = sp - 1 - int'(imm[31:0]);
                        held = operand_words[sp-1];
                        operand_words[sp-1] = operand_words[far_idx];
                        operand_words[far_idx] = held;
                        fetch_pc = pc_inc;
                    end
                end
                OP_DROP: begin
                    if (imm > t_word'(sp)) begin
                        fault = FAULT_UNDER;
                    end else begin
                        word_count = sp - int'(imm[31:0]);
                        fetch_pc = pc_inc;
                    end
                end
                OP_EQ, OP_GE, OP_ADD: begin
                    if (sp < 2) begin
                        fault = FAULT_UNDER;
                    end else begin
                        rhs = operand_words[sp-1];
                        lhs = operand_words[sp-2];
                        if (op == OP_EQ) begin
                            operand_words[sp-2] = (lhs == rhs) ? t_word'(1) : '0;
                        end else if (op == OP_GE) begin
                            operand_words[sp-2] = ($signed(lhs) >= $signed(rhs)) ?
                                t_word'(1) : '0;
                        end else begin
                            operand_words[sp-2] = lhs + rhs;
                        end
                        word_count = sp - 1;
                        fetch_pc = pc_inc;
                    end
                end
                default: begin
                    fetch_pc = pc_inc;
                end
            endcase
        end
        status.next_pc   = NPC_BITS'(fetch_pc);
        status.top_value = (word_count != 0) ? operand_words[word_count-1] : '0;
        status.depth     = DEPTH_BITS'(word_count);
        status.halted    = halt_seen;
        status.fault     = fault;
    endtask

    function automatic t_word pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return WORD_MAX;
            2: return WORD_MIN;
            3: return '1;
            4, 5: return t_word'($urandom_range(0, 40));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly short gaps, a few long ones, and bursts with none
    function automatic int pick_gap();
        int roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one word, hold it until accepted, record the expected status
    task automatic issue_instr(input logic [OP_BITS-1:0] op, input t_word imm,
                               input bit typed, input t_machine_status typed_status);
        t_machine_status predicted;
        int gap;
        start       <= 1'b1;
        i_op        <= op;
        i_immediate <= imm;
        do @(posedge i_clk); while (busy !== 1'b0);
        execute_instr(op, imm, predicted);
        if (typed) begin
            pending_status = {pending_status, typed_status};
        end else begin
            pending_status = {pending_status, predicted};
        end
        accepted_count++;
        if (word_count > peak_depth) peak_depth = word_count;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Mostly well-formed instructions for the current depth, some noise
    task automatic issue_mixed();
        logic [OP_BITS-1:0] op;
        t_word              imm;
        int unsigned        sp;
        int                 roll;
        sp   = word_count;
        roll = $urandom_range(0, 99);
        imm  = pick_word();
        if (roll < 8) begin
            op = OP_BITS'($urandom_range(int'(OP_PUSH), int'(OP_SPARE_HI)));
        end else if (sp < 2 || (roll < 40 && sp < 48)) begin
            op = OP_PUSH;
        end else begin
            case ($urandom_range(0, 9))
                0: begin
                    op  = OP_DUP;
                    imm = t_word'($urandom_range(0, sp - 1));
                end
                1: begin
                    op  = OP_SWAP;
                    imm = t_word'($urandom_range(0, sp - 1));
                end
                2: begin
                    op  = OP_DROP;
                    imm = t_word'($urandom_range(0, (sp > 6) ? 6 : sp));
                end
                3: op = OP_EQ;
                4: op = OP_GE;
                5: op = OP_ADD;
                6: op = OP_JZ;
                7: op = OP_RET;
                8: op = OP_JUMP;
                default: op = ($urandom_range(0, 1) != 0) ? OP_LABEL : OP_SPARE_LO;
            endcase
        end
        issue_instr(op, imm, 1'b0, no_status);
    endtask

    // Check each strobed result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_machine_status want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_status.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, pc %h depth %0d",
                                          o_next_pc, o_depth));
            end else begin
                want = pending_status.pop_front();
                checked_count++;
                if (o_next_pc !== want.next_pc)
                    report_mismatch($sformatf("result %0d next_pc %h, expected %h",
                                              checked_count, o_next_pc, want.next_pc));
                if (o_top_value !== want.top_value)
                    report_mismatch($sformatf("result %0d top_value %h, expected %h",
                                              checked_count, o_top_value, want.top_value));
                if (o_depth !== want.depth)
                    report_mismatch($sformatf("result %0d depth %0d, expected %0d",
                                              checked_count, o_depth, want.depth));
                if (o_halted !== want.halted)
                    report_mismatch($sformatf("result %0d halted %b, expected %b",
                                              checked_count, o_halted, want.halted));
                if (o_fault !== want.fault)
                    report_mismatch($sformatf("result %0d fault %0d, expected %0d",
                                              checked_count, o_fault, want.fault));
            end
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_status.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        t_machine_status row_status;
        int unsigned     step;

        // Empty-stack faults, extremes, signed compare, pc truncation and wrap
        directed_rows = '{
            '{OP_JZ,       64'd5,    1'b1, 16'd0, 64'd0,    11'd0, 1'b0, FAULT_UNDER},
            '{OP_RET,      64'd0,    1'b1, 16'd0, 64'd0,    11'd0, 1'b0, FAULT_UNDER},
            '{OP_ADD,      64'd0,    1'b1, 16'd0, 64'd0,    11'd0, 1'b0, FAULT_UNDER},
            '{OP_DUP,      64'd0,    1'b1, 16'd0, 64'd0,    11'd0, 1'b0, FAULT_UNDER},
            '{OP_DROP,     64'd1,    1'b1, 16'd0, 64'd0,    11'd0, 1'b0, FAULT_UNDER},
            '{OP_PUSH,     WORD_MAX, 1'b1, 16'd1, WORD_MAX, 11'd1, 1'b0, FAULT_NONE},
            '{OP_PUSH,     WORD_MIN, 1'b1, 16'd2, WORD_MIN, 11'd2, 1'b0, FAULT_NONE},
            '{OP_GE,       64'd0,    1'b1, 16'd3, 64'd1,    11'd1, 1'b0, FAULT_NONE},
            '{OP_EQ,       64'd0,    1'b1, 16'd3, 64'd1,    11'd1, 1'b0, FAULT_UNDER},
            '{OP_SWAP,     '1,       1'b1, 16'd3, 64'd1,    11'd1, 1'b0, FAULT_UNDER},
            '{OP_DROP,     '1,       1'b1, 16'd3, 64'd1,    11'd1, 1'b0, FAULT_UNDER},
            '{OP_DUP,      64'd0,    1'b0, 16'd0, 64'd0,    11'd0, 1'b0, FAULT_NONE},
            '{OP_PUSH,     '1,       1'b0, 16'd0, 64'd0,    11'd0, 1'b0, FAULT_NONE},
            '{OP_ADD,      64'd0,    1'b0, 16'd0, 64'd0,    11'd0, 1'b0, FAULT_NONE},
            '{OP_GE,       64'd0,    1'b0, 16'd0, 64'd0,    11'd0, 1'b0, FAULT_NONE},
            '{OP_PUSH,     64'd0,    1'b0, 16'd0, 64'd0,    11'd0, 1'b0, FAULT_NONE},
            '{OP_JZ, 64'hABCD_0000_0000_FFF0, 1'b0, 16'd0, 64'd0, 11'd0, 1'b0, FAULT_NONE},
            '{OP_LABEL,    64'd0,    1'b0, 16'd0, 64'd0,    11'd0, 1'b0, FAULT_NONE},
            '{OP_SPARE_LO, WORD_MIN, 1'b0, 16'd0, 64'd0,    11'd0, 1'b0, FAULT_NONE},
            '{OP_SPARE_HI, '1,       1'b0, 16'd0, 64'd0,    11'd0, 1'b0, FAULT_NONE},
            '{OP_JUMP,     '1,       1'b0, 16'd0, 64'd0,    11'd0, 1'b0, FAULT_NONE},
            '{OP_LABEL,    64'd0,    1'b0, 16'd0, 64'd0,    11'd0, 1'b0, FAULT_NONE},
            '{OP_PUSH, 64'h1234_5678_0000_0042, 1'b0, 16'd0, 64'd0, 11'd0, 1'b0, FAULT_NONE},
            '{OP_RET,      64'd0,    1'b0, 16'd0, 64'd0,    11'd0, 1'b0, FAULT_NONE},
            '{OP_DROP,     64'd1,    1'b0, 16'd0, 64'd0,    11'd0, 1'b0, FAULT_NONE}
        };

        // Hold reset, then release
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (directed_rows[n]) begin
            row_status.next_pc   = directed_rows[n].next_pc;
            row_status.top_value = directed_rows[n].top_value;
            row_status.depth     = directed_rows[n].depth;
            row_status.halted    = directed_rows[n].halted;
            row_status.fault     = directed_rows[n].fault;
            issue_instr(directed_rows[n].op, directed_rows[n].imm,
                        directed_rows[n].typed, row_status);
        end

        // Mixed traffic at shallow depth
        repeat (MIXED_ITEMS) issue_mixed();

        // Climb to a full stack, touching deep entries on the way
        while (word_count < STACK_WORDS) begin
            step = $urandom_range(0, 9);
            if (word_count == 0 || step > 1) begin
                issue_instr(OP_PUSH, pick_word(), 1'b0, no_status);
            end else if (step == 0) begin
                issue_instr(OP_DUP, t_word'($urandom_range(0, word_count - 1)),
                            1'b0, no_status);
            end else begin
                issue_instr(OP_SWAP, t_word'($urandom_range(0, word_count - 1)),
                            1'b0, no_status);
            end
        end

        // Overflow at the top, then the deepest legal accesses, then empty it
        issue_instr(OP_PUSH, pick_word(), 1'b0, no_status);
        issue_instr(OP_DUP, t_word'(0), 1'b0, no_status);
        issue_instr(OP_DUP, t_word'(STACK_WORDS), 1'b0, no_status);
        issue_instr(OP_SWAP, t_word'(STACK_WORDS - 1), 1'b0, no_status);
        issue_instr(OP_GE, pick_word(), 1'b0, no_status);
        issue_instr(OP_DUP, t_word'(STACK_WORDS - 2), 1'b0, no_status);
        issue_instr(OP_DROP, t_word'(STACK_WORDS + 1), 1'b0, no_status);
        issue_instr(OP_DROP, t_word'(STACK_WORDS), 1'b0, no_status);

        // More mixed traffic from empty
        repeat (MIXED_ITEMS) issue_mixed();

        // Halt last; everything after it is ignored
        issue_instr(OP_HALT, pick_word(), 1'b0, no_status);
        issue_instr(OP_PUSH, pick_word(), 1'b0, no_status);
        issue_instr(OP_JUMP, pick_word(), 1'b0, no_status);
        issue_instr(OP_DROP, '1, 1'b0, no_status);
        issue_instr(OP_HALT, '0, 1'b0, no_status);

        // Drain outstanding results
        start <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d instructions, checked %0d results, peak stack depth %0d",
                 accepted_count, checked_count, peak_depth);
        $display("Covered empty and full stack faults, deep dup/swap, pc wrap and halt");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
